>>> src/hmp_pkg.sv
// shared constants and controller/datapath interface types for the message padder
package hmp_pkg;

  // input kind codes carried in tuser
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FINAL = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BLOCK_IS_128   = 2'd0;
  localparam logic [1:0] CFG_LENGTH_IS_16   = 2'd1;
  localparam logic [1:0] CFG_LENGTH_LITTLE  = 2'd2;

  // output word selection
  localparam logic [2:0] SEL_MSG  = 3'd0;
  localparam logic [2:0] SEL_PAD  = 3'd1;
  localparam logic [2:0] SEL_ZERO = 3'd2;
  localparam logic [2:0] SEL_LEN0 = 3'd3;
  localparam logic [2:0] SEL_LEN1 = 3'd4;

  // commands from the controller
  typedef struct packed {
    logic       push;      // absorb the incoming message byte
    logic       load_out;  // load the output register
    logic [2:0] sel;       // which word to load
    logic       last;      // mark the loaded word as end of message
    logic       clear;     // return partial word and byte count to zero
  } dp_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic       out_free;  // output register can take a word this cycle
    logic       fill7;     // seven bytes held, the next byte completes a word
    logic [3:0] word_idx;  // word position within a 128-byte block
    logic       blk128;
    logic       len16;
  } dp_status_t;

endpackage

>>> src/hmp_datapath.sv
// datapath: config registers, partial word, byte counter, word select and output register
module hmp_datapath import hmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_wdata_i,
  input  logic [7:0] data_byte_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t sts_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [63:0] out_word_o,
  output logic       out_last_o
);

  logic        blk128_q, len16_q, little_q;
  logic [55:0] partial_q, partial_d;
  logic [63:0] count_q, count_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_word_q;
  logic        out_last_q;
  logic [63:0] word_sel;
  logic [63:0] len_lo, len_hi;
  logic [5:0]  pad_shift;
  logic        out_free;

  function automatic logic [63:0] bswap(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk128_q <= 1'b0;
      len16_q  <= 1'b0;
      little_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLOCK_IS_128:  blk128_q <= cfg_wdata_i;
        CFG_LENGTH_IS_16:  len16_q  <= cfg_wdata_i;
        CFG_LENGTH_LITTLE: little_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // partial word and byte count
  always_comb begin
    partial_d = partial_q;
    count_d   = count_q;
    if (cmd_i.clear) begin
      partial_d = '0;
      count_d   = '0;
    end else if (cmd_i.push) begin
      count_d   = count_q + 64'd1;
      partial_d = (count_q[2:0] == 3'd7) ? 56'd0 : {partial_q[47:0], data_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      count_q   <= '0;
    end else begin
      partial_q <= partial_d;
      count_q   <= count_d;
    end
  end

  // bit length of the message, low and high halves
  assign len_lo    = {count_q[60:0], 3'b000};
  assign len_hi    = {61'd0, count_q[63:61]};
  assign pad_shift = {~count_q[2:0], 3'b000};

  // word selection
  always_comb begin
    unique case (cmd_i.sel)
      SEL_MSG:  word_sel = {partial_q, data_byte_i};
      SEL_PAD:  word_sel = {partial_q, 8'h80} << pad_shift;
      SEL_ZERO: word_sel = '0;
      SEL_LEN0: begin
        if (little_q)     word_sel = bswap(len_lo);
        else if (len16_q) word_sel = len_hi;
        else              word_sel = len_lo;
      end
      SEL_LEN1: word_sel = little_q ? bswap(len_hi) : len_lo;
      default:  word_sel = '0;
    endcase
  end

  // output register
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = cmd_i.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_word_q <= word_sel;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_last_o  = out_last_q;

  assign sts_o.out_free = out_free;
  assign sts_o.fill7    = (count_q[2:0] == 3'd7);
  assign sts_o.word_idx = count_q[6:3];
  assign sts_o.blk128   = blk128_q;
  assign sts_o.len16    = len16_q;

endmodule

>>> src/hmp_ctrl.sv
// controller: accepts beats and sequences the padding words
module hmp_ctrl import hmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_LEN0 = 3'd3;
  localparam logic [2:0] ST_LEN1 = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] widx_q, widx_d;
  logic [3:0] idx_mask, len_start, widx_next;
  logic       accept;

  // word positions within the current block
  assign idx_mask  = sts_i.blk128 ? 4'hF : 4'h7;
  assign len_start = idx_mask - {3'd0, sts_i.len16};

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    widx_d    = widx_q;
    widx_next = '0;
    cmd_o     = '{push: 1'b0, load_out: 1'b0, sel: SEL_MSG, last: 1'b0, clear: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (kind_i == KIND_BYTE || kind_i == KIND_FINAL) begin
            cmd_o.push     = 1'b1;
            cmd_o.load_out = sts_i.fill7;
            cmd_o.sel      = SEL_MSG;
            if (kind_i == KIND_FINAL) state_d = ST_PAD;
          end else if (kind_i == KIND_END) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = SEL_PAD;
          widx_next      = (sts_i.word_idx + 4'd1) & idx_mask;
          widx_d         = widx_next;
          state_d        = (widx_next == len_start) ? ST_LEN0 : ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = SEL_ZERO;
          widx_next      = (widx_q + 4'd1) & idx_mask;
          widx_d         = widx_next;
          state_d        = (widx_next == len_start) ? ST_LEN0 : ST_ZERO;
        end
      end
      ST_LEN0: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = SEL_LEN0;
          cmd_o.last     = !sts_i.len16;
          cmd_o.clear    = !sts_i.len16;
          state_d        = sts_i.len16 ? ST_LEN1 : ST_IDLE;
        end
      end
      ST_LEN1: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = SEL_LEN1;
          cmd_o.last     = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      widx_q  <= widx_d;
    end
  end

`ifndef ASSERT_OFF
  // never overwrite a word that has not been taken
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("output register loaded while occupied");

  // zero fill never runs into the length field
  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ZERO) |-> (widx_q != len_start))
    else $error("zero fill at length field position");

  // second length word only with a 16-byte field
  a_len1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEN1) |-> sts_i.len16)
    else $error("second length word with 8-byte field");

  // a finished message leaves counter state cleared and returns to idle
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> (state_q == ST_IDLE) && (sts_i.word_idx == 4'd0) && !sts_i.fill7)
    else $error("state not cleared after end of message");
`endif

endmodule

>>> src/hash_message_padder.sv
// top level of the hash message padder
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/tready         tdata: data_byte; tuser: kind
//  m_axis    out        m_axis_tvalid/tready         tdata: word; tlast: end_of_message
//  cfg       in         cfg_we_i (no wait)           cfg_index_i, cfg_wdata_i
//
// a message byte is taken whenever the controller is idle and the output register is free
// an end beat or a final byte beat is taken, then the padding sequencer emits one word
// per cycle while the output register is free, 2 to 18 words as the block position and
// field size need; the single output register is shared with message words
// no input beat is taken while padding words are being emitted
// output stalls hold the word in the output register and hold back input
// reset clears configuration, byte count and partial word; no clearing pass
module hash_message_padder import hmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] word
  output logic        m_axis_tlast
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer
  hmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .kind_i     (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  hmp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_byte_i (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_word_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
